// ===== rtl/gspt_pkg.sv =====
// ----------------------------------------------------------------------------
// gspt_pkg
// Shared types and constants for the gyro swing peak/trough detector.
// ----------------------------------------------------------------------------
package gspt_pkg;

   localparam int RATE_W  = 16;   // raw gyro rate sample
   localparam int MS_W    = 10;   // elapsed milliseconds
   localparam int INC_W   = 26;   // angle increment, 1/131000 degree
   localparam int TOT_W   = 30;   // running window total
   localparam int THR_W   = 26;   // threshold registers
   localparam int CODE_W  = 2;
   localparam int REQ_W   = 32;   // request tdata, padded to whole bytes
   localparam int RSP_W   = 32;   // response tdata
   localparam int CSR_IDX_W = 1;

   localparam logic signed [THR_W-1:0] ON_THR_RESET  = THR_W'(393000);
   localparam logic signed [THR_W-1:0] OFF_THR_RESET = '0;

   typedef enum logic [CODE_W-1:0] {
      EVT_NONE = 2'd0,
      EVT_ON   = 2'd1,
      EVT_OFF  = 2'd2
   } event_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ON_THR  = 1'b0,
      CSR_OFF_THR = 1'b1
   } csr_index_type;

   // running totals handed from the window to the detector
   typedef struct packed {
      logic signed [TOT_W-1:0] cur_total;
      logic signed [TOT_W-1:0] prev_total;
   } totals_type;

endpackage

// ===== rtl/gspt_ram.sv =====
// ----------------------------------------------------------------------------
// gspt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gspt_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gspt_window.sv =====
// ----------------------------------------------------------------------------
// gspt_window
// Increment ring and running total; the oldest entry is prefetched so that
// the registered ram read does not hold up the total update on a request.
// ----------------------------------------------------------------------------
module gspt_window #(
   parameter int WINDOW_LEN = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic signed [gspt_pkg::INC_W-1:0]   increment,
   output gspt_pkg::totals_type                totals
);
   import gspt_pkg::*;

   localparam int POS_W = $clog2(WINDOW_LEN);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW_LEN - 1);

   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    filled_ff, filled_in;
   logic signed [TOT_W-1:0] total_ff, total_in;
   logic [POS_W-1:0]        rd_addr;
   logic [INC_W-1:0]        rd_data;
   logic signed [INC_W-1:0] oldest;

   gspt_ram #(
      .WIDTH (INC_W),
      .DEPTH (WINDOW_LEN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (step),
      .wr_addr (pos_ff),
      .wr_data (increment),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // slots not yet written since reset read as zero
   assign oldest = filled_ff ? signed'(rd_data) : '0;

   always_comb begin
      pos_in    = pos_ff;
      filled_in = filled_ff;
      if (step) begin
         if (pos_ff == LAST_POS) begin
            pos_in    = '0;
            filled_in = 1'b1;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   // read ahead the slot the next request will overwrite
   assign rd_addr = pos_in;

   assign total_in = total_ff
                   + {{(TOT_W-INC_W){increment[INC_W-1]}}, increment}
                   - {{(TOT_W-INC_W){oldest[INC_W-1]}}, oldest};

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         filled_ff <= 1'b0;
         total_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         filled_ff <= filled_in;
         if (step) begin
            total_ff <= total_in;
         end
      end
   end

   assign totals.cur_total  = total_in;
   assign totals.prev_total = total_ff;

endmodule

// ===== rtl/gspt_detect.sv =====
// ----------------------------------------------------------------------------
// gspt_detect
// Level and direction tests with arming, and the response register.
// ----------------------------------------------------------------------------
module gspt_detect #(
   parameter int WINDOW_LEN = 10
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       step,
   input  gspt_pkg::totals_type                       totals,
   input  logic signed [gspt_pkg::THR_W+$clog2(WINDOW_LEN+1)-1:0] on_level,
   input  logic signed [gspt_pkg::THR_W+$clog2(WINDOW_LEN+1)-1:0] off_level,
   input  logic                                       rsp_tready,
   output logic                                       rsp_tvalid,
   output logic [gspt_pkg::RSP_W-1:0]                 rsp_tdata
);
   import gspt_pkg::*;

   localparam int LVL_W = THR_W + $clog2(WINDOW_LEN + 1);
   localparam int CMP_W = (LVL_W > TOT_W) ? LVL_W : TOT_W;

   logic signed [CMP_W-1:0] cur_x, prev_x, on_x, off_x;
   logic                    on_armed_ff, on_armed_in;
   logic                    off_armed_ff, off_armed_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   event_code_type          code_in, code_ff;
   logic signed [TOT_W-1:0] total_ff;
   logic                    fire_on, fire_off;

   assign cur_x  = CMP_W'(totals.cur_total);
   assign prev_x = CMP_W'(totals.prev_total);
   assign on_x   = CMP_W'(on_level);
   assign off_x  = CMP_W'(off_level);

   assign fire_on  = (cur_x > on_x) && (cur_x > prev_x) && on_armed_ff;
   assign fire_off = (cur_x < off_x) && (cur_x < prev_x) && off_armed_ff;

   always_comb begin
      code_in      = EVT_NONE;
      on_armed_in  = on_armed_ff;
      off_armed_in = off_armed_ff;
      if (fire_on) begin
         code_in      = EVT_ON;
         on_armed_in  = 1'b0;
         off_armed_in = 1'b1;
      end
      if (fire_off) begin
         code_in      = EVT_OFF;
         off_armed_in = 1'b0;
         on_armed_in  = 1'b1;
      end
   end

   assign rsp_valid_in = step | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         on_armed_ff  <= 1'b1;
         off_armed_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            on_armed_ff  <= on_armed_in;
            off_armed_ff <= off_armed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         code_ff  <= code_in;
         total_ff <= totals.cur_total;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {total_ff, code_ff};

endmodule

// ===== rtl/gyro_swing_peak_trough_detector_top.sv =====
// ----------------------------------------------------------------------------
// gyro_swing_peak_trough_detector_top
// Moving-window total of gyro angle increments with armed peak/trough events.
// ----------------------------------------------------------------------------
// path: a request passes the input register, then the response register,
//   before response valid
// throughput: one request per cycle unless rsp_tready stalls; the oldest
//   ring slot is prefetched via the registered ram read to keep pace
// reset: synchronous; totals and ring position clear, both events armed,
//   thresholds to defaults; ring slots read as zero until first written
// ----------------------------------------------------------------------------
module gyro_swing_peak_trough_detector_top #(
   parameter int WINDOW_LEN = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: [15:0] rate_sample, [25:16] elapsed_ms, [31:26] zero
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [gspt_pkg::REQ_W-1:0]       req_tdata,
   // response: [1:0] event_code, [31:2] window_total
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [gspt_pkg::RSP_W-1:0]       rsp_tdata,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gspt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gspt_pkg::THR_W-1:0]       csr_wdata
);
   import gspt_pkg::*;

   localparam int LVL_W = THR_W + $clog2(WINDOW_LEN + 1);
   localparam logic signed [LVL_W-1:0] WIN_MULT = LVL_W'(WINDOW_LEN);
   localparam logic signed [LVL_W-1:0] ON_LVL_RESET =
      LVL_W'(393000 * WINDOW_LEN);

   logic signed [RATE_W-1:0] rate;
   logic [MS_W-1:0]          ms;
   logic signed [INC_W-1:0]  inc_in, inc_ff;
   logic                     stage_valid_ff;
   logic                     step;
   logic                     req_accept;
   logic signed [LVL_W-1:0]  wdata_ext, level_in;
   logic signed [LVL_W-1:0]  on_level_ff, off_level_ff;
   totals_type               totals;

   assign rate = signed'(req_tdata[RATE_W-1:0]);
   assign ms   = req_tdata[RATE_W +: MS_W];

   assign inc_in = {{(INC_W-RATE_W){rate[RATE_W-1]}}, rate}
                 * signed'({{(INC_W-MS_W){1'b0}}, ms});

   // a request in the input register moves on once the response slot frees
   assign step       = stage_valid_ff & (~rsp_tvalid | rsp_tready);
   assign req_tready = ~stage_valid_ff | step;
   assign req_accept = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= req_accept | (stage_valid_ff & ~step);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         inc_ff <= inc_in;
      end
   end

   // thresholds are kept pre-scaled by the window length
   assign csr_ready = 1'b1;
   assign wdata_ext = {{(LVL_W-THR_W){csr_wdata[THR_W-1]}}, csr_wdata};
   assign level_in  = wdata_ext * WIN_MULT;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_level_ff  <= ON_LVL_RESET;
         off_level_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ON_THR: begin
               on_level_ff <= level_in;
            end
            CSR_OFF_THR: begin
               off_level_ff <= level_in;
            end
         endcase
      end
   end

   gspt_window #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .increment (inc_ff),
      .totals    (totals)
   );

   gspt_detect #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_detect (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .totals     (totals),
      .on_level   (on_level_ff),
      .off_level  (off_level_ff),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== dv/gyro_swing_peak_trough_detector_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gyro_swing_peak_trough_detector_top_tb
// Streams gyro rate samples into the detector in bursts of random length.
// Every accepted request updates a local copy of the increment window and the
// armed flags, and each response is checked in order against the predicted
// window total and swing event, while the thresholds are moved between runs.
// ----------------------------------------------------------------------------
module gyro_swing_peak_trough_detector_top_tb;
   import gspt_pkg::*;

   localparam int WINDOW         = 10;
   localparam int PHASE_ITEMS    = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 10;

   // packed so that a cast lines up with the request tdata layout
   typedef struct packed {
      logic [MS_W-1:0]          ms;
      logic signed [RATE_W-1:0] rate;
   } gyro_sample_type;

   typedef struct packed {
      event_code_type          code;
      logic signed [TOT_W-1:0] total;
   } swing_outcome_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_ONE_IN_THREE,
      READY_BURSTY
   } ready_pattern_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [THR_W-1:0]     csr_wdata  = '0;

   // local copy of the detector state
   logic signed [INC_W-1:0] inc_ring [WINDOW];
   int                      ring_slot;
   logic signed [TOT_W-1:0] win_total;
   logic                    on_armed;
   logic                    off_armed;
   logic signed [THR_W-1:0] on_thr;
   logic signed [THR_W-1:0] off_thr;

   gyro_sample_type   pending_samples [$];
   swing_outcome_type expected_outcomes [$];
   swing_outcome_type oldest_outcome;

   int                mismatch_count = 0;
   int                rsp_count      = 0;
   int                burst_left     = 0;
   int                gap_left       = 0;
   int                stall_tick     = 0;
   ready_pattern_type stall_mode     = READY_ALWAYS;
   int                quiet_cycles   = 0;

   always #5 clock = ~clock;

   gyro_swing_peak_trough_detector_top #(
      .WINDOW_LEN(WINDOW)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   function automatic void clear_window();
      for (int i = 0; i < WINDOW; i++) inc_ring[i] = '0;
      ring_slot = 0;
      win_total = '0;
      on_armed  = 1'b1;
      off_armed = 1'b1;
      on_thr    = ON_THR_RESET;
      off_thr   = OFF_THR_RESET;
   endfunction

   // one sample in: slide the window, then test for a trough or peak crossing
   function automatic void advance_window(gyro_sample_type s);
      longint            inc;
      longint            sum;
      longint            prev;
      longint            cur;
      longint            on_lvl;
      longint            off_lvl;
      swing_outcome_type outc;
      inc  = longint'(s.rate) * longint'(s.ms);
      prev = longint'(win_total);
      sum  = prev + inc - longint'(inc_ring[ring_slot]);
      inc_ring[ring_slot] = inc[INC_W-1:0];
      ring_slot = (ring_slot + 1) % WINDOW;
      win_total = sum[TOT_W-1:0];
      cur     = longint'(win_total);
      on_lvl  = longint'(on_thr) * WINDOW;
      off_lvl = longint'(off_thr) * WINDOW;
      outc.code = EVT_NONE;
      if (cur > on_lvl && cur > prev && on_armed) begin
         outc.code = EVT_ON;
         on_armed  = 1'b0;
         off_armed = 1'b1;
      end
      if (cur < off_lvl && cur < prev && off_armed) begin
         outc.code = EVT_OFF;
         off_armed = 1'b0;
         on_armed  = 1'b1;
      end
      outc.total = win_total;
      expected_outcomes.push_back(outc);
   endfunction

   // request driver: bursts of random length, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            advance_window(gyro_sample_type'(req_tdata[RATE_W+MS_W-1:0]));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_tdata  <= REQ_W'(pending_samples.pop_front());
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 12)
                                                           : $urandom_range(0, 2);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready follows a pattern that is picked anew at random periodically
   always @(posedge clock) begin
      stall_tick++;
      if (stall_tick % 300 == 0)
         stall_mode = ready_pattern_type'($urandom_range(0, 3));
      case (stall_mode)
         READY_ALWAYS:       rsp_tready <= 1'b1;
         READY_RANDOM:       rsp_tready <= 1'($urandom_range(0, 1));
         READY_ONE_IN_THREE: rsp_tready <= (stall_tick % 3 == 0);
         default:            rsp_tready <= (stall_tick % 16 < 5);
      endcase
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (expected_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("response %0d not expected: tdata %h", rsp_count, rsp_tdata);
         end else begin
            oldest_outcome = expected_outcomes.pop_front();
            if (rsp_tdata[CODE_W-1:0] !== oldest_outcome.code ||
                rsp_tdata[CODE_W+TOT_W-1:CODE_W] !== oldest_outcome.total) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response %0d: expected code %0d total %0d, got code %0d total %0d",
                           rsp_count, oldest_outcome.code, oldest_outcome.total,
                           rsp_tdata[CODE_W-1:0],
                           $signed(rsp_tdata[CODE_W+TOT_W-1:CODE_W]));
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("gyro_swing_peak_trough_detector_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(csr_index_type idx, logic signed [THR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ON_THR) on_thr = value;
      else off_thr = value;
   endtask

   // checked on the falling edge so that the rising-edge updates have settled
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || expected_outcomes.size() != 0);
   endtask

   function automatic void queue_sample(logic signed [RATE_W-1:0] rate, logic [MS_W-1:0] ms);
      gyro_sample_type s;
      s.rate = rate;
      s.ms   = ms;
      pending_samples.push_back(s);
   endfunction

   // triangle-shaped swing with jitter, the kind of trace a walking leg gives
   task automatic queue_swing(int len);
      int amp;
      int period;
      int jit;
      int ms_base;
      int ph;
      int val;
      int noise;
      amp     = $urandom_range(500, 32767);
      period  = $urandom_range(6, 40);
      jit     = $urandom_range(0, amp / 8);
      ms_base = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 1020)
                                            : $urandom_range(1, 60);
      for (int k = 0; k < len; k++) begin
         ph = k % period;
         if (2 * ph < period) val = -amp + (4 * amp * ph) / period;
         else val = 3 * amp - (4 * amp * ph) / period;
         noise = $urandom_range(0, 2 * jit);
         val   = val + noise - jit;
         if (val > 32767) val = 32767;
         if (val < -32768) val = -32768;
         queue_sample(RATE_W'(val), MS_W'(ms_base + $urandom_range(0, 3)));
      end
   endtask

   task automatic queue_noise(int len);
      logic signed [RATE_W-1:0] rate;
      logic [MS_W-1:0]          ms;
      for (int k = 0; k < len; k++) begin
         case ($urandom_range(0, 5))
            0:       rate = 16'sh7fff;
            1:       rate = 16'sh8000;
            default: rate = RATE_W'($urandom);
         endcase
         ms = ($urandom_range(0, 3) == 0) ? 10'd1023 : MS_W'($urandom);
         queue_sample(rate, ms);
      end
   endtask

   task automatic run_phase(int n);
      int chunk;
      @(negedge clock);
      while (n > 0) begin
         chunk = $urandom_range(1, 60);
         if (chunk > n) chunk = n;
         if ($urandom_range(0, 4) == 0) queue_noise(chunk);
         else queue_swing(chunk);
         n -= chunk;
      end
      wait_drained();
   endtask

   initial begin
      int thr_a;
      int thr_b;
      clear_window();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset thresholds: flat start, full-scale swing up then down, edge values
      queue_sample(16'sd0, 10'd0);
      queue_sample(16'sd32767, 10'd1023);
      queue_sample(16'sd32767, 10'd1023);
      queue_sample(-16'sd32768, 10'd1023);
      queue_sample(-16'sd32768, 10'd1023);
      queue_sample(-16'sd32768, 10'd1023);
      queue_sample(-16'sd1, 10'd1);
      queue_sample(16'sd1, 10'd1);
      queue_sample(16'sd0, 10'd1023);
      queue_sample(16'sd32767, 10'd0);
      queue_sample(-16'sd32768, 10'd0);
      queue_sample(-16'sd1, 10'd1023);
      queue_sample(16'sh5555, 10'h2aa);
      queue_sample(16'shaaaa, 10'h155);
      // a full window of zero increments flushes the total back to zero
      for (int k = 0; k < 10; k++) queue_sample(16'sd0, 10'd0);
      wait_drained();

      write_csr(CSR_ON_THR, 26'sh1ffffff);
      write_csr(CSR_OFF_THR, -26'sh2000000);
      run_phase(PHASE_ITEMS);

      write_csr(CSR_ON_THR, -26'sh2000000);
      write_csr(CSR_OFF_THR, 26'sh1ffffff);
      run_phase(PHASE_ITEMS);

      write_csr(CSR_ON_THR, '0);
      write_csr(CSR_OFF_THR, '0);
      run_phase(PHASE_ITEMS);

      for (int p = 0; p < 2; p++) begin
         thr_a = $urandom_range(0, 400000);
         thr_b = $urandom_range(0, 400000);
         write_csr(CSR_ON_THR, THR_W'(thr_a));
         write_csr(CSR_OFF_THR, THR_W'(-thr_b));
         run_phase(PHASE_ITEMS);
      end

      write_csr(CSR_OFF_THR, THR_W'($urandom));
      write_csr(CSR_ON_THR, THR_W'($urandom));
      run_phase(PHASE_ITEMS);

      write_csr(CSR_ON_THR, ON_THR_RESET);
      write_csr(CSR_OFF_THR, OFF_THR_RESET);
      run_phase(PHASE_ITEMS);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
         $display("gyro_swing_peak_trough_detector_top: match");
      end else begin
         $display("gyro_swing_peak_trough_detector_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== gyro_swing_peak_trough_detector_top.f =====
rtl/gspt_pkg.sv
rtl/gspt_ram.sv
rtl/gspt_window.sv
rtl/gspt_detect.sv
rtl/gyro_swing_peak_trough_detector_top.sv
dv/gyro_swing_peak_trough_detector_top_tb.sv
